>>> rtl/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

  typedef logic [2:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PREDICT,
    OP_SUM,
    OP_DIV,
    OP_MULX,
    OP_UPDX,
    OP_MULP,
    OP_UPDP,
    OP_RELOAD
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_RELOAD,
    COND_LOOP
  } cond_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  done;
  } ctrl_word_t;

  typedef struct packed {
    logic kind;
    logic out_busy;
  } dp_status_t;

  localparam logic [1:0] REG_PROCESS_NOISE   = 2'd0;
  localparam logic [1:0] REG_INIT_ESTIMATE   = 2'd1;
  localparam logic [1:0] REG_INIT_COVARIANCE = 2'd2;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_RELOAD = 1'b1;

  localparam logic [30:0] RST_PROCESS_NOISE   = 31'd3277;
  localparam logic [31:0] RST_INIT_ESTIMATE   = 32'd0;
  localparam logic [30:0] RST_INIT_COVARIANCE = 31'd65536;

  localparam step_t STEP_PREDICT = 3'd0;
  localparam step_t STEP_SUM     = 3'd1;
  localparam step_t STEP_DIV     = 3'd2;
  localparam step_t STEP_MULX    = 3'd3;
  localparam step_t STEP_UPDX    = 3'd4;
  localparam step_t STEP_MULP    = 3'd5;
  localparam step_t STEP_UPDP    = 3'd6;
  localparam step_t STEP_RELOAD  = 3'd7;

  localparam ctrl_word_t NOP_WORD = '{op: OP_NOP, cond: COND_NONE,
                                      target: STEP_PREDICT, done: 1'b0};

  // Microprogram: one control word per step.
  function automatic ctrl_word_t ctrl_rom(input step_t s);
    ctrl_word_t w;
    w = NOP_WORD;
    case (s)
      STEP_PREDICT: begin
        w.op     = OP_PREDICT;
        w.cond   = COND_RELOAD;
        w.target = STEP_RELOAD;
      end
      STEP_SUM:  w.op = OP_SUM;
      STEP_DIV: begin
        w.op     = OP_DIV;
        w.cond   = COND_LOOP;
        w.target = STEP_DIV;
      end
      STEP_MULX: w.op = OP_MULX;
      STEP_UPDX: w.op = OP_UPDX;
      STEP_MULP: w.op = OP_MULP;
      STEP_UPDP: begin
        w.op   = OP_UPDP;
        w.done = 1'b1;
      end
      STEP_RELOAD: begin
        w.op   = OP_RELOAD;
        w.done = 1'b1;
      end
      default: w = NOP_WORD;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/skf_ifs.sv
`timescale 1ns / 1ps

interface skf_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] measurement;
  logic [30:0] noise_cov;

  modport source (output valid, kind, measurement, noise_cov, input ready);
  modport sink (input valid, kind, measurement, noise_cov, output ready);
endinterface

interface skf_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] estimate;

  modport source (output valid, estimate, input ready);
  modport sink (input valid, estimate, output ready);
endinterface

interface skf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/skf_seq.sv
`timescale 1ns / 1ps

module skf_seq import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_word_t ctrl,
  output logic       idle
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  seq_state_t     state, state_next;
  step_t          step, step_next;
  logic [CW-1:0]  cnt, cnt_next;
  ctrl_word_t     word;
  logic           stall;
  logic           taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      step  <= STEP_PREDICT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    word       = ctrl_rom(step);
    // hold the final step until the output register is free
    stall      = word.done && status.out_busy;
    ctrl       = NOP_WORD;
    state_next = state;
    step_next  = step;
    cnt_next   = cnt;
    taken      = 1'b0;
    idle       = (state == SEQ_IDLE);
    case (word.cond)
      COND_NONE:   taken = 1'b0;
      COND_RELOAD: taken = (status.kind == KIND_RELOAD);
      COND_LOOP:   taken = (cnt != '0);
      default:     taken = 1'b0;
    endcase
    case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_RUN;
          step_next  = STEP_PREDICT;
        end
      end
      SEQ_RUN: begin
        if (!stall) begin
          ctrl = word;
          if (word.op == OP_SUM) begin
            cnt_next = CW'(FRAC_BITS);
          end else if (word.op == OP_DIV) begin
            cnt_next = cnt - 1'b1;
          end
          if (word.done) begin
            state_next = SEQ_IDLE;
          end else if (taken) begin
            step_next = word.target;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

endmodule

>>> rtl/skf_dp.sv
`timescale 1ns / 1ps

module skf_dp import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_word_t  ctrl,
  input  logic        start,
  input  logic        in_kind,
  input  logic [31:0] in_measurement,
  input  logic [30:0] in_noise_cov,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_estimate,
  output dp_status_t  status
);

  localparam int KW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 35;
  localparam logic [KW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic [30:0] process_noise;
  logic [31:0] init_estimate;
  logic [30:0] init_covariance;

  logic signed [31:0] x;
  logic [31:0]        pcov;
  logic [31:0]        pp;
  logic [32:0]        s;
  logic [33:0]        rem;
  logic [KW-1:0]      q;
  logic signed [PW-1:0] prod;
  logic signed [31:0] z;
  logic [30:0]        r;
  logic               kind;

  logic [32:0]          pred_sum;
  logic [31:0]          pred_sat;
  logic                 div_ge;
  logic [33:0]          div_sub;
  logic [KW-1:0]        k_eff;
  logic signed [32:0]   diff;
  logic signed [32:0]   ma;
  logic signed [KW:0]   mb;
  logic signed [PW-1:0] rsh;
  logic signed [PW-1:0] x_sum;
  logic [31:0]          x_sat;
  logic [31:0]          p_new;
  logic signed [31:0]   x_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise   <= RST_PROCESS_NOISE;
      init_estimate   <= RST_INIT_ESTIMATE;
      init_covariance <= RST_INIT_COVARIANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE:   process_noise   <= cfg_data[30:0];
        REG_INIT_ESTIMATE:   init_estimate   <= cfg_data;
        REG_INIT_COVARIANCE: init_covariance <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind <= in_kind;
      z    <= in_measurement;
      r    <= in_noise_cov;
    end
  end

  always_comb begin
    pred_sum = {1'b0, pcov} + {2'b0, process_noise};
    pred_sat = pred_sum[32] ? '1 : pred_sum[31:0];
    div_ge   = (rem >= {1'b0, s});
    div_sub  = div_ge ? (rem - {1'b0, s}) : rem;
    // zero sum means zero gain
    k_eff    = (s == '0) ? '0 : q;
    diff     = {z[31], z} - {x[31], x};
    if (ctrl.op == OP_MULP) begin
      ma = {1'b0, pp};
      mb = {1'b0, ONE - k_eff};
    end else begin
      ma = diff;
      mb = {1'b0, k_eff};
    end
    rsh   = (prod + HALF) >>> FRAC_BITS;
    x_sum = PW'(x) + rsh;
    if (x_sum[PW-1:31] == '0 || x_sum[PW-1:31] == '1) begin
      x_sat = x_sum[31:0];
    end else begin
      x_sat = x_sum[PW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    p_new = (rsh[PW-1:32] == '0) ? rsh[31:0] : '1;
    case (ctrl.op)
      OP_UPDX:   x_next = x_sat;
      OP_RELOAD: x_next = init_estimate;
      default:   x_next = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x    <= '0;
      pcov <= 32'(ONE);
    end else begin
      x <= x_next;
      case (ctrl.op)
        OP_UPDP:   pcov <= p_new;
        OP_RELOAD: pcov <= {1'b0, init_covariance};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_PREDICT: pp <= pred_sat;
      OP_SUM: begin
        s   <= {1'b0, pp} + {2'b0, r};
        rem <= {2'b0, pp};
        q   <= '0;
      end
      OP_DIV: begin
        rem <= {div_sub[32:0], 1'b0};
        q   <= {q[KW-2:0], div_ge};
      end
      OP_MULX, OP_MULP: prod <= ma * mb;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      out_estimate <= x_next;
    end
  end

  assign status.kind     = kind;
  assign status.out_busy = out_valid && !out_ready;

endmodule

>>> rtl/scalar_kalman_filter.sv
`timescale 1ns / 1ps

// One-dimensional Kalman filter, signed fixed point with FRAC_BITS fraction bits.
// req (sink): one request per item; kind selects a measurement update (measurement,
//   noise_cov) or a reload of estimate and covariance from the init registers.
// rsp (source): one estimate per request, in request order.
// cfg (sink): register writes, always ready; index 0 process noise, 1 initial
//   estimate, 2 initial covariance; other indexes are dropped.
// A microcoded sequencer steps the adders, a restoring divider (one quotient
// bit per cycle) and one multiplier. An update runs FRAC_BITS+7 steps, the
// divide loop taking FRAC_BITS+1 of them. rsp.valid and req.ready rise together
// once the final step is done, so the block takes no new request while one is in
// flight. A reload runs only the predict and reload steps.
// req.ready is high while the sequencer is idle; a result left in the output
// register does not block the next request. If the receiver stalls, the last
// step of the following item waits until the output register is free.
// Reset clears the estimate to zero, sets covariance to 1.0 and loads the
// register defaults.
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  skf_req_if.sink  req,
  skf_rsp_if.source rsp,
  skf_cfg_if.sink  cfg
);

  ctrl_word_t ctrl;
  dp_status_t status;
  logic       idle;
  logic       start;

  assign req.ready = idle;
  assign start     = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  skf_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  skf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .start          (start),
    .in_kind        (req.kind),
    .in_measurement (req.measurement),
    .in_noise_cov   (req.noise_cov),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_estimate   (rsp.estimate),
    .status         (status)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    start |=> !req.ready)
    else $error("request accepted while sequencer not idle");

  a_done_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |-> !status.out_busy)
    else $error("result written over an unread result");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(ctrl.done))
    else $error("response raised without a finished program");

endmodule

>>> verif/scalar_kalman_filter_test.sv
`timescale 1ns / 1ps

module scalar_kalman_filter_test;
  import skf_pkg::*;

  localparam int          FRAC_BITS   = 16;
  localparam logic [63:0] GAIN_ONE    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_LSB    = GAIN_ONE >> 1;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 40;

  logic clk;
  logic rst;

  skf_req_if req_if ();
  skf_rsp_if rsp_if ();
  skf_cfg_if cfg_if ();

  scalar_kalman_filter dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // Filter state and registers as the block should hold them
  logic [31:0] est_q;
  logic [31:0] cov_q;
  logic [30:0] noise_q;
  logic [31:0] init_est_q;
  logic [30:0] init_cov_q;

  logic [31:0] pending_estimates[$];
  logic [31:0] expected_estimate;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          recv_hold_cycles = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_filter_state();
    est_q      = '0;
    cov_q      = 32'd1 << FRAC_BITS;
    noise_q    = RST_PROCESS_NOISE;
    init_est_q = RST_INIT_ESTIMATE;
    init_cov_q = RST_INIT_COVARIANCE;
  endfunction

  function automatic void store_register(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      REG_PROCESS_NOISE:   noise_q    = data[30:0];
      REG_INIT_ESTIMATE:   init_est_q = data;
      REG_INIT_COVARIANCE: init_cov_q = data[30:0];
      default: ;
    endcase
  endfunction

  // Advance the filter by one request and return the estimate it reports
  function automatic logic [31:0] filter_step(input logic kind, input logic [31:0] z,
                                             input logic [30:0] r);
    logic [32:0] p_sum;
    logic [31:0] p_pred;
    logic [32:0] denom;
    logic [63:0] gain;
    logic [63:0] p_scaled;
    longint      diff;
    longint      corr;
    longint      x_new;
    if (kind == KIND_RELOAD) begin
      est_q = init_est_q;
      cov_q = {1'b0, init_cov_q};
    end else begin
      p_sum  = {1'b0, cov_q} + {2'b00, noise_q};
      p_pred = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
      denom  = {1'b0, p_pred} + {2'b00, r};
      gain   = (denom == '0) ? 64'd0 : ({32'd0, p_pred} << FRAC_BITS) / {31'd0, denom};
      if (gain > GAIN_ONE) gain = GAIN_ONE;
      diff  = longint'($signed(z)) - longint'($signed(est_q));
      // floor of (diff*gain + half) / one rounds to nearest, ties up
      corr  = (diff * longint'(gain) + longint'(HALF_LSB)) >>> FRAC_BITS;
      x_new = longint'($signed(est_q)) + corr;
      if (x_new > 64'sd2147483647) x_new = 64'sd2147483647;
      if (x_new < -64'sd2147483648) x_new = -64'sd2147483648;
      est_q    = x_new[31:0];
      p_scaled = ((GAIN_ONE - gain) * {32'd0, p_pred} + HALF_LSB) >> FRAC_BITS;
      cov_q    = p_scaled[31:0];
    end
    return est_q;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Result checker and receiver readiness
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch($sformatf("estimate %h with no request outstanding", rsp_if.estimate));
      end else begin
        expected_estimate = pending_estimates.pop_front();
        if (rsp_if.estimate !== expected_estimate)
          report_mismatch($sformatf("estimate %h, expected %h",
                                    rsp_if.estimate, expected_estimate));
      end
    end
    if (recv_hold_cycles > 0) begin
      rsp_if.ready <= 1'b0;
      recv_hold_cycles--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Hang: no handshake for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Leaves valid high on return; the next request or a drain decides its level
  task automatic send_request(input logic kind, input logic [31:0] z, input logic [30:0] r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.measurement <= z;
    req_if.noise_cov   <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_estimates.push_back(filter_step(kind, z, r));
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (pending_estimates.size() != 0 || !req_if.ready) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    store_register(idx, data);
  endtask

  task automatic configure_filter(input logic [31:0] q_word, input logic [31:0] est_word,
                                  input logic [31:0] cov_word);
    wait_for_results();
    write_register(REG_PROCESS_NOISE, q_word);
    write_register(REG_INIT_ESTIMATE, est_word);
    write_register(REG_INIT_COVARIANCE, cov_word);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Unsigned registers ignore bit 31; set it at random to show that
  function automatic logic [31:0] random_cov_word();
    logic [31:0] w;
    case ($urandom_range(3))
      0: w = 32'd0;
      1: w = 32'h7FFF_FFFF;
      2: w = $urandom_range(0, 32'h0004_0000);
      default: w = $urandom();
    endcase
    return w | ($urandom() & 32'h8000_0000);
  endfunction

  task automatic random_settings();
    logic [31:0] est_word;
    if ($urandom_range(1)) est_word = $urandom();
    else est_word = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    configure_filter(random_cov_word(), est_word, random_cov_word());
  endtask

  // Mostly measurements near the current estimate with modest noise
  task automatic random_request(output logic kind, output logic [31:0] z,
                                output logic [30:0] r);
    longint near_val;
    kind = ($urandom_range(99) < 8) ? KIND_RELOAD : KIND_UPDATE;
    if ($urandom_range(9) < 3) begin
      z = $urandom();
    end else begin
      near_val = longint'($signed(est_q)) + longint'($urandom_range(0, 32'h0010_0000))
                 - 64'sd524288;
      if (near_val > 64'sd2147483647) near_val = 64'sd2147483647;
      if (near_val < -64'sd2147483648) near_val = -64'sd2147483648;
      z = near_val[31:0];
    end
    case ($urandom_range(9))
      0, 1: r = 31'($urandom());
      2: r = '0;
      default: r = 31'($urandom_range(0, 32'h0004_0000));
    endcase
  endtask

  task automatic test_reset_defaults();
    send_request(KIND_UPDATE, 32'h0001_0000, 31'h0001_0000);
    send_request(KIND_UPDATE, 32'hFFFD_8000, 31'h0000_4000);
    send_request(KIND_RELOAD, 32'h1234_5678, 31'h7654_3210);
  endtask

  task automatic test_field_extremes();
    send_request(KIND_UPDATE, 32'h7FFF_FFFF, 31'd0);
    send_request(KIND_UPDATE, 32'h8000_0000, 31'd0);
    send_request(KIND_UPDATE, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_request(KIND_UPDATE, 32'h8000_0000, 31'h7FFF_FFFF);
    send_request(KIND_UPDATE, 32'd0, 31'd1);
    send_request(KIND_UPDATE, 32'hFFFF_FFFF, 31'h4000_0000);
    send_request(KIND_RELOAD, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
  endtask

  // No process noise and zero covariance: gain is zero, nothing moves
  task automatic test_zero_sum();
    configure_filter(32'd0, 32'h0001_8000, 32'd0);
    send_request(KIND_RELOAD, 32'd0, 31'd0);
    send_request(KIND_UPDATE, 32'h7FFF_FFFF, 31'd0);
    send_request(KIND_UPDATE, 32'h0000_0005, 31'd3);
    send_request(KIND_UPDATE, 32'h8000_0000, 31'd0);
  endtask

  task automatic test_register_extremes();
    configure_filter(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(KIND_RELOAD, 32'd0, 31'd0);
    send_request(KIND_UPDATE, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_request(KIND_UPDATE, 32'd0, 31'd0);
    configure_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(KIND_RELOAD, 32'd0, 31'd0);
    send_request(KIND_UPDATE, 32'h8000_0000, 31'h7FFF_FFFF);
  endtask

  // Out-of-range index must leave every register alone
  task automatic test_unused_register();
    wait_for_results();
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_if.valid <= 1'b0;
    send_request(KIND_RELOAD, 32'd0, 31'd0);
    send_request(KIND_UPDATE, 32'h0002_0000, 31'h0000_8000);
  endtask

  task automatic test_random_traffic(input int n_items);
    logic        kind;
    logic [31:0] z;
    logic [30:0] r;
    repeat (2) begin
      random_settings();
      repeat (n_items / 2) begin
        random_request(kind, z, r);
        send_request(kind, z, r);
      end
    end
  endtask

  // Hold the receiver off long enough that the block stops taking requests
  task automatic test_backpressure();
    logic        kind;
    logic [31:0] z;
    logic [30:0] r;
    random_settings();
    recv_hold_cycles = HOLD_CYCLES;
    repeat (30) begin
      random_request(kind, z, r);
      send_request(kind, z, r);
    end
    wait_for_results();
  endtask

  initial begin
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.kind        <= KIND_UPDATE;
    req_if.measurement <= '0;
    req_if.noise_cov   <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_PROCESS_NOISE;
    cfg_if.data        <= '0;
    reset_filter_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_idling(26, 75);
    test_reset_defaults();
    test_field_extremes();
    test_zero_sum();
    test_register_extremes();
    test_unused_register();
    test_random_traffic(200);

    set_idling(75, 26);
    test_random_traffic(200);

    set_idling(0, 0);
    test_backpressure();
    test_random_traffic(200);

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_estimates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
